FILE: hw/rtl/lz77_token_decompressor_top_assert.svh
// assertion macros for the lz77 token decompressor
// used by lz77_token_decompressor_top, no other dependencies
`ifndef LZ77_TOKEN_DECOMPRESSOR_TOP_ASSERT_SVH
`define LZ77_TOKEN_DECOMPRESSOR_TOP_ASSERT_SVH

// condition implies consequence in the same cycle
`define LZD_ASSERT_NOW(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error(msg);

// condition implies consequence in the next cycle
`define LZD_ASSERT_NEXT(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/lzd_pkg.sv
// package for the lz77 token decompressor: parse phases, status codes, controller states
// no dependencies
`timescale 1ns / 1ps

package lzd_pkg;

  typedef enum logic [1:0] {
    PH_CMD = 2'd0,
    PH_LIT = 2'd1,
    PH_DHI = 2'd2,
    PH_DLO = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_TRUNCATED = 3'd1,
    ST_ZERO_DIST = 3'd2,
    ST_TOO_FAR   = 3'd3,
    ST_CAPACITY  = 3'd4
  } status_t;

  // controller states
  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_COPY  = 2'd1,
    S_FLUSH = 2'd2,
    S_CLOSE = 2'd3
  } ctl_t;

  localparam logic [7:0] MATCH_FLAG = 8'h80;
  localparam logic [6:0] LEN_MASK   = 7'h7F;
  localparam logic [7:0] MATCH_BIAS = 8'd4;

endpackage

FILE: hw/rtl/lz77_token_decompressor_top.sv
// lz77 token decompressor top level: parser, history memory, copy engine, output stage
// depends on lzd_pkg and lz77_token_decompressor_top_assert.svh
`timescale 1ns / 1ps

// Takes the compressed stream one beat per byte. Command and distance bytes are
// taken one per cycle while the output register is free. Each literal byte leaves
// as its own one-byte result beat, since each input byte's results close with
// run_end, so a literal is first accepted and then its beat is flushed. A match of
// L bytes holds the input after its last distance byte while the copy engine
// issues the first read, then writes one history byte back per cycle unless a
// full group stalls it (history memory with one read and one write port and a
// registered read, forwarding the byte just written when a copy overlaps
// itself), and then flushes the last group. A full group that cannot leave
// stalls the copy. The final byte adds the close state and the closing beat.
// One output register separates the result side; a new byte is taken only when
// that register is empty or drains in the same cycle.
`include "lz77_token_decompressor_top_assert.svh"

module lz77_token_decompressor_top #(
  parameter int HISTORY_DEPTH    = 65536,
  parameter int BYTES_PER_RESULT = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_stream_byte,
  input  logic        in_final_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_out_bytes,
  output logic [3:0]  out_byte_count,
  output logic        out_run_end,
  output logic        out_stream_done,
  output logic [2:0]  out_status,
  output logic [31:0] out_total_length,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);

  localparam int AW = $clog2(HISTORY_DEPTH);
  localparam int CW = $clog2(BYTES_PER_RESULT + 1);

  // history memory
  logic [7:0]    mem [HISTORY_DEPTH];
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]    mem_wdata, mem_rdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata <= mem[mem_raddr];
  end

  // state
  lzd_pkg::ctl_t    ctl_r, ctl_nxt;
  lzd_pkg::phase_t  phase_r, phase_nxt;
  logic [6:0]       lit_left_r, lit_left_nxt;
  logic [7:0]       mlen_r, mlen_nxt;
  logic [7:0]       dhi_r, dhi_nxt;
  logic [2:0]       err_r, err_nxt;
  logic [AW-1:0]    wp_r, wp_nxt;
  logic [31:0]      prod_r, prod_nxt;
  logic [31:0]      cap_r;
  logic             fin_r, fin_nxt;
  // copy engine
  logic [AW-1:0]    src_r, src_nxt;
  logic [7:0]       left_r, left_nxt;   // reads still to issue
  logic             rd_pend_r, rd_pend_nxt;
  logic [AW-1:0]    rd_addr_r, rd_addr_nxt;
  logic [7:0]       lastw_r, lastw_nxt;
  logic [AW-1:0]    lastw_addr_r, lastw_addr_nxt;
  logic             lastw_v_r, lastw_v_nxt;
  // group accumulator
  logic [63:0]      acc_r, acc_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  // output register
  logic             ov_r, ov_nxt;
  logic [63:0]      ob_r, ob_nxt;
  logic [3:0]       oc_r, oc_nxt;
  logic             oe_r, oe_nxt, od_r, od_nxt;
  logic [2:0]       os_r, os_nxt;
  logic [31:0]      ot_r, ot_nxt;

  logic             in_fire, out_free;
  logic [15:0]      match_dist;
  logic [7:0]       cbyte;
  logic [CW-1:0]    cnt_inc;

  assign out_free   = !ov_r || out_ready;
  assign in_ready   = (ctl_r == lzd_pkg::S_IDLE) && out_free;
  assign in_fire    = in_valid && in_ready;
  assign match_dist = {dhi_r, in_stream_byte};
  assign cbyte      = (lastw_v_r && lastw_addr_r == rd_addr_r) ? lastw_r : mem_rdata;
  assign cnt_inc    = cnt_r + CW'(1);

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= '1;
    end else if (cfg_we) begin
      cap_r <= cfg_wdata;
    end
  end

  // controller next state and datapath
  always_comb begin
    ctl_nxt = ctl_r;     phase_nxt = phase_r;   lit_left_nxt = lit_left_r;
    mlen_nxt = mlen_r;   dhi_nxt = dhi_r;       err_nxt = err_r;
    wp_nxt = wp_r;       prod_nxt = prod_r;     fin_nxt = fin_r;
    src_nxt = src_r;     left_nxt = left_r;     rd_pend_nxt = 1'b0;
    rd_addr_nxt = rd_addr_r;
    lastw_nxt = lastw_r; lastw_addr_nxt = lastw_addr_r; lastw_v_nxt = lastw_v_r;
    acc_nxt = acc_r;     cnt_nxt = cnt_r;
    ov_nxt = ov_r && !out_ready;
    ob_nxt = ob_r; oc_nxt = oc_r; oe_nxt = oe_r; od_nxt = od_r;
    os_nxt = os_r; ot_nxt = ot_r;
    mem_we = 1'b0; mem_waddr = wp_r; mem_wdata = in_stream_byte; mem_raddr = src_r;
    case (ctl_r)
      lzd_pkg::S_IDLE: begin
        if (in_fire) begin
          fin_nxt = in_final_byte;
          if (err_r == lzd_pkg::ST_OK) begin
            case (phase_r)
              lzd_pkg::PH_CMD: begin
                if (in_stream_byte < lzd_pkg::MATCH_FLAG) begin
                  lit_left_nxt = in_stream_byte[6:0];
                  phase_nxt = (in_stream_byte != 8'd0) ? lzd_pkg::PH_LIT : lzd_pkg::PH_CMD;
                end else begin
                  mlen_nxt = {1'b0, in_stream_byte[6:0] & lzd_pkg::LEN_MASK}
                             + lzd_pkg::MATCH_BIAS;
                  phase_nxt = lzd_pkg::PH_DHI;
                end
              end
              lzd_pkg::PH_LIT: begin
                if ({1'b0, prod_r} + 33'd1 > {1'b0, cap_r}) begin
                  err_nxt = lzd_pkg::ST_CAPACITY;
                end else begin
                  mem_we = 1'b1;
                  lastw_nxt = in_stream_byte; lastw_addr_nxt = wp_r; lastw_v_nxt = 1'b1;
                  wp_nxt = wp_r + AW'(1);
                  prod_nxt = prod_r + 32'd1;
                  lit_left_nxt = lit_left_r - 7'd1;
                  if (lit_left_r == 7'd1) phase_nxt = lzd_pkg::PH_CMD;
                  acc_nxt = 64'(in_stream_byte);
                  cnt_nxt = CW'(1);
                end
              end
              lzd_pkg::PH_DHI: begin
                dhi_nxt = in_stream_byte;
                phase_nxt = lzd_pkg::PH_DLO;
              end
              default: begin
                phase_nxt = lzd_pkg::PH_CMD;
                if (match_dist == 16'd0) begin
                  err_nxt = lzd_pkg::ST_ZERO_DIST;
                end else if ({16'd0, match_dist} > prod_r) begin
                  err_nxt = lzd_pkg::ST_TOO_FAR;
                end else if ({1'b0, prod_r} + {25'd0, mlen_r} > {1'b0, cap_r}) begin
                  err_nxt = lzd_pkg::ST_CAPACITY;
                end else begin
                  src_nxt = wp_r - AW'(match_dist);
                  left_nxt = mlen_r;
                end
              end
            endcase
          end
          if (left_nxt != 8'd0) ctl_nxt = lzd_pkg::S_COPY;
          else if (cnt_nxt != '0) ctl_nxt = lzd_pkg::S_FLUSH;
          else if (in_final_byte) ctl_nxt = lzd_pkg::S_CLOSE;
        end
      end
      lzd_pkg::S_COPY: begin
        // read issue
        if (left_r != 8'd0) begin
          mem_raddr = src_r;
          rd_pend_nxt = 1'b1;
          rd_addr_nxt = src_r;
          src_nxt = src_r + AW'(1);
          left_nxt = left_r - 8'd1;
        end
        // write back the byte read last cycle, with forwarding
        if (rd_pend_r) begin
          if (cnt_r == CW'(BYTES_PER_RESULT) && !out_free) begin
            // hold: stall read engine too
            rd_pend_nxt = 1'b1; src_nxt = src_r; left_nxt = left_r;
            mem_raddr = rd_addr_r; rd_addr_nxt = rd_addr_r;
            // re-read the same address
            src_nxt = rd_addr_r + AW'(1);
            left_nxt = left_r;
          end else begin
            if (cnt_r == CW'(BYTES_PER_RESULT)) begin
              ov_nxt = 1'b1; ob_nxt = acc_r; oc_nxt = 4'(cnt_r);
              oe_nxt = 1'b0; od_nxt = 1'b0; os_nxt = lzd_pkg::ST_OK; ot_nxt = 32'd0;
              acc_nxt = 64'(cbyte); cnt_nxt = CW'(1);
            end else begin
              acc_nxt = acc_r | (64'(cbyte) << (8 * cnt_r));
              cnt_nxt = cnt_inc;
            end
            mem_we = 1'b1; mem_waddr = wp_r; mem_wdata = cbyte;
            lastw_nxt = cbyte; lastw_addr_nxt = wp_r; lastw_v_nxt = 1'b1;
            wp_nxt = wp_r + AW'(1);
            prod_nxt = prod_r + 32'd1;
            if (left_r == 8'd0) ctl_nxt = lzd_pkg::S_FLUSH;
          end
        end
      end
      lzd_pkg::S_FLUSH: begin
        if (out_free) begin
          ov_nxt = 1'b1; ob_nxt = acc_r; oc_nxt = 4'(cnt_r);
          oe_nxt = !fin_r; od_nxt = 1'b0; os_nxt = lzd_pkg::ST_OK; ot_nxt = 32'd0;
          acc_nxt = 64'd0; cnt_nxt = '0;
          ctl_nxt = fin_r ? lzd_pkg::S_CLOSE : lzd_pkg::S_IDLE;
        end
      end
      default: begin
        if (out_free) begin
          ov_nxt = 1'b1; ob_nxt = 64'd0; oc_nxt = 4'd0; oe_nxt = 1'b1; od_nxt = 1'b1;
          os_nxt = (err_r == lzd_pkg::ST_OK && phase_r != lzd_pkg::PH_CMD)
                   ? lzd_pkg::ST_TRUNCATED : err_r;
          ot_nxt = prod_r;
          phase_nxt = lzd_pkg::PH_CMD; lit_left_nxt = 7'd0; mlen_nxt = 8'd0;
          dhi_nxt = 8'd0; err_nxt = lzd_pkg::ST_OK; wp_nxt = '0; prod_nxt = 32'd0;
          fin_nxt = 1'b0; lastw_v_nxt = 1'b0;
          ctl_nxt = lzd_pkg::S_IDLE;
        end
      end
    endcase
  end

  // registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= lzd_pkg::S_IDLE;   phase_r <= lzd_pkg::PH_CMD;
      lit_left_r <= '0; mlen_r <= '0; dhi_r <= '0; err_r <= '0;
      wp_r <= '0; prod_r <= '0; fin_r <= 1'b0; left_r <= '0; rd_pend_r <= 1'b0;
      lastw_v_r <= 1'b0; cnt_r <= '0; acc_r <= '0; ov_r <= 1'b0;
    end else begin
      ctl_r <= ctl_nxt;   phase_r <= phase_nxt;
      lit_left_r <= lit_left_nxt; mlen_r <= mlen_nxt; dhi_r <= dhi_nxt; err_r <= err_nxt;
      wp_r <= wp_nxt; prod_r <= prod_nxt; fin_r <= fin_nxt; left_r <= left_nxt;
      rd_pend_r <= rd_pend_nxt; lastw_v_r <= lastw_v_nxt; cnt_r <= cnt_nxt;
      acc_r <= acc_nxt; ov_r <= ov_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    src_r <= src_nxt; rd_addr_r <= rd_addr_nxt;
    lastw_r <= lastw_nxt; lastw_addr_r <= lastw_addr_nxt;
    ob_r <= ob_nxt; oc_r <= oc_nxt; oe_r <= oe_nxt; od_r <= od_nxt;
    os_r <= os_nxt; ot_r <= ot_nxt;
  end

  assign out_valid        = ov_r;
  assign out_out_bytes    = ob_r;
  assign out_byte_count   = oc_r;
  assign out_run_end      = oe_r;
  assign out_stream_done  = od_r;
  assign out_status       = os_r;
  assign out_total_length = ot_r;

  `LZD_ASSERT_NOW(a_no_accept_busy, in_fire, ctl_r == lzd_pkg::S_IDLE, "accept while busy")
  `LZD_ASSERT_NOW(a_done_empty, out_valid && out_stream_done, out_byte_count == 4'd0,
                  "closing beat carries data")
  `LZD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result beat dropped")
  `LZD_ASSERT_NOW(a_cnt_range, 1'b1, cnt_r <= CW'(BYTES_PER_RESULT), "group overfull")

endmodule
